// ===== design/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define AME_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define AME_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");
`else
`define AME_ASSERT(label, clk, rst, prop)
`define AME_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== design/ame_pkg.sv =====
`default_nettype none

package ame_pkg;

   localparam int MEMORY_WORDS = 4096;
   localparam int MEM_ADDR_W   = (MEMORY_WORDS > 1) ? $clog2(MEMORY_WORDS) : 1;
   localparam int WORD_W       = 16;
   localparam int ADDR_W       = 12;
   localparam int OPCODE_W     = 4;

   localparam logic CMD_EXECUTE = 1'b0;
   localparam logic CMD_WRITE   = 1'b1;

   localparam logic [OPCODE_W-1:0] OP_STORE = 4'd0;
   localparam logic [OPCODE_W-1:0] OP_LOAD  = 4'd1;
   localparam logic [OPCODE_W-1:0] OP_JMPZ  = 4'd2;
   localparam logic [OPCODE_W-1:0] OP_ADD   = 4'd3;
   localparam logic [OPCODE_W-1:0] OP_SUB   = 4'd4;
   localparam logic [OPCODE_W-1:0] OP_OR    = 4'd5;
   localparam logic [OPCODE_W-1:0] OP_AND   = 4'd6;
   localparam logic [OPCODE_W-1:0] OP_XOR   = 4'd7;
   localparam logic [OPCODE_W-1:0] OP_NOT   = 4'd8;
   localparam logic [OPCODE_W-1:0] OP_INC   = 4'd9;
   localparam logic [OPCODE_W-1:0] OP_DEC   = 4'd10;
   localparam logic [OPCODE_W-1:0] OP_ZERO  = 4'd11;

   typedef struct packed {
      logic              command;
      logic [WORD_W-1:0] instruction_word;
      logic [ADDR_W-1:0] load_address;
      logic [WORD_W-1:0] load_value;
   } req_type;

   typedef struct packed {
      logic              jump_taken;
      logic [WORD_W-1:0] accumulator_value;
   } rsp_type;

   typedef struct packed {
      logic              jump_taken;
      logic [WORD_W-1:0] accumulator;
   } alu_result_type;

endpackage

`default_nettype wire

// ===== design/ame_alu.sv =====
`default_nettype none

module ame_alu
   import ame_pkg::*;
(
   input  wire logic [OPCODE_W-1:0] opcode,
   input  wire logic [WORD_W-1:0]   acc,
   input  wire logic [WORD_W-1:0]   operand,
   output alu_result_type           result
);

   always_comb begin
      result.jump_taken  = 1'b0;
      result.accumulator = acc;
      unique case (opcode)
         OP_STORE: result.accumulator = acc;
         OP_LOAD:  result.accumulator = operand;
         OP_JMPZ:  result.jump_taken  = (acc == '0);
         OP_ADD:   result.accumulator = acc + operand;
         OP_SUB:   result.accumulator = acc - operand;
         OP_OR:    result.accumulator = acc | operand;
         OP_AND:   result.accumulator = acc & operand;
         OP_XOR:   result.accumulator = acc ^ operand;
         OP_NOT:   result.accumulator = ~acc;
         OP_INC:   result.accumulator = acc + WORD_W'(1);
         OP_DEC:   result.accumulator = acc - WORD_W'(1);
         OP_ZERO:  result.accumulator = '0;
         default:  result.accumulator = acc;
      endcase
   end

endmodule

`default_nettype wire

// ===== design/accumulator_machine_execute.sv =====
// A request accepted is registered into stage 1 along with its data memory read.
// Throughput: one request per cycle unless the response is stalled by rsp_ready low;
// the execute stage then reads, modifies and writes back, and registers the response.
// Reset: synchronous, active high; clears the accumulator, then a clearing pass zeroes
// the data memory, one word a cycle, with req_ready low.
`default_nettype none
`include "assert_macros.svh"

module accumulator_machine_execute
   import ame_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_payload
);

   logic [WORD_W-1:0] mem [MEMORY_WORDS];

   logic                  clearing_ff, clearing_in;
   logic [MEM_ADDR_W-1:0] clear_addr_ff, clear_addr_in;

   logic              s1_valid_ff, s1_valid_in;
   req_type           s1_req_ff;
   logic [WORD_W-1:0] rd_data_ff;

   logic              fwd_valid_ff, fwd_valid_in;
   logic [ADDR_W-1:0] fwd_addr_ff;
   logic [WORD_W-1:0] fwd_data_ff;

   logic [WORD_W-1:0] acc_ff, acc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              req_fire, s1_fire;
   logic [ADDR_W-1:0] s1_addr, rd_addr, wr_addr;
   logic              s1_in_range, wr_in_range;
   logic [WORD_W-1:0] operand;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [WORD_W-1:0] mem_wdata;
   alu_result_type    alu_res;

   function automatic logic in_range(input logic [ADDR_W-1:0] addr);
      return {1'b0, addr} < (ADDR_W + 1)'(MEMORY_WORDS);
   endfunction

   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !clearing_ff && (!s1_valid_ff || s1_fire);
   assign req_fire  = req_valid && req_ready;

   assign rd_addr     = req_payload.instruction_word[ADDR_W-1:0];
   assign s1_addr     = s1_req_ff.instruction_word[ADDR_W-1:0];
   assign s1_in_range = in_range(s1_addr);

   always_comb begin
      if (!s1_in_range) begin
         operand = '0;
      end else if (fwd_valid_ff && fwd_addr_ff == s1_addr) begin
         operand = fwd_data_ff;
      end else begin
         operand = rd_data_ff;
      end
   end

   ame_alu u_alu (
      .opcode  (s1_req_ff.instruction_word[WORD_W-1 -: OPCODE_W]),
      .acc     (acc_ff),
      .operand (operand),
      .result  (alu_res)
   );

   assign wr_addr = (s1_req_ff.command == CMD_WRITE) ? s1_req_ff.load_address : s1_addr;
   assign wr_in_range = in_range(wr_addr);

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = wr_addr;
      mem_wdata = (s1_req_ff.command == CMD_WRITE) ? s1_req_ff.load_value : acc_ff;
      if (clearing_ff) begin
         mem_we    = 1'b1;
         mem_waddr = ADDR_W'(clear_addr_ff);
         mem_wdata = '0;
      end else if (s1_fire && wr_in_range) begin
         mem_we = (s1_req_ff.command == CMD_WRITE) ||
                  (s1_req_ff.instruction_word[WORD_W-1 -: OPCODE_W] == OP_STORE);
      end
   end

   always_comb begin
      clearing_in   = clearing_ff;
      clear_addr_in = clear_addr_ff;
      if (clearing_ff) begin
         clear_addr_in = clear_addr_ff + MEM_ADDR_W'(1);
         if (clear_addr_ff == MEM_ADDR_W'(MEMORY_WORDS - 1)) begin
            clearing_in = 1'b0;
         end
      end

      s1_valid_in = req_fire || (s1_valid_ff && !s1_fire);
      fwd_valid_in = fwd_valid_ff || mem_we;

      acc_in       = acc_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
         if (s1_req_ff.command == CMD_WRITE) begin
            rsp_in.jump_taken        = 1'b0;
            rsp_in.accumulator_value = acc_ff;
         end else begin
            acc_in                   = alu_res.accumulator;
            rsp_in.jump_taken        = alu_res.jump_taken;
            rsp_in.accumulator_value = alu_res.accumulator;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr[MEM_ADDR_W-1:0]] <= mem_wdata;
      end
      if (req_fire) begin
         rd_data_ff <= mem[rd_addr[MEM_ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clear_addr_ff <= '0;
         s1_valid_ff   <= 1'b0;
         fwd_valid_ff  <= 1'b0;
         acc_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         clearing_ff   <= clearing_in;
         clear_addr_ff <= clear_addr_in;
         s1_valid_ff   <= s1_valid_in;
         fwd_valid_ff  <= fwd_valid_in;
         acc_ff        <= acc_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      if (req_fire) begin
         s1_req_ff <= req_payload;
      end
      if (mem_we) begin
         fwd_addr_ff <= mem_waddr;
         fwd_data_ff <= mem_wdata;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `AME_ASSERT(a_no_req_while_clearing, clock, reset, clearing_ff |-> !req_ready)
   `AME_ASSERT(a_clear_runs_once, clock, reset, !clearing_ff |=> !clearing_ff)
   `AME_ASSERT(a_req_enters_stage, clock, reset, req_fire |=> s1_valid_ff)
   `AME_ASSERT(a_write_keeps_acc, clock, reset,
      (s1_fire && s1_req_ff.command == CMD_WRITE) |=> acc_ff == $past(acc_ff))
   `AME_ASSERT(a_jump_only_on_zero, clock, reset,
      (rsp_valid_ff && rsp_ff.jump_taken) |-> rsp_ff.accumulator_value == '0)

endmodule

`default_nettype wire
